/* rtl/core/dq_pkg.sv */
`timescale 1ns / 1ps

package dq_pkg;

    localparam int DEPTH   = 16;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int COUNT_W = $clog2(DEPTH + 1);
    localparam int KEY_W   = 32;
    localparam int AGE_W   = 8;
    localparam int CMD_W   = 3;
    localparam int STAT_W  = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_BACK    = 3'd0,
        CMD_PUSH_FRONT   = 3'd1,
        CMD_POP_FRONT    = 3'd2,
        CMD_POP_BACK     = 3'd3,
        CMD_UPDATE_FRONT = 3'd4
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [AGE_W-1:0] age;
    } t_rec;

endpackage

/* rtl/core/double_ended_queue_core.sv */
`timescale 1ns / 1ps

// Channel   Transfer when          Ports
// command   start && !busy         i_cmd, i_entry_key, i_entry_age
// result    o_valid (one cycle)    o_status, o_occupancy, o_front_key, o_front_age,
//                                  o_removed_key, o_removed_age
//
// One command per cycle; its result is registered and shows in the cycle after the transfer.
// The records sit in a register row with the front record in slot 0; every
// command is one pass of shift/write/select logic into that row.
// busy stays low: a command is taken in every cycle, no clearing pass.
// Synchronous active-low reset empties the queue; the receiver cannot stall.

module double_ended_queue_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [dq_pkg::CMD_W-1:0]        i_cmd,
    input  logic [dq_pkg::KEY_W-1:0]        i_entry_key,
    input  logic [dq_pkg::AGE_W-1:0]        i_entry_age,
    output logic                            o_valid,
    output logic [dq_pkg::STAT_W-1:0]       o_status,
    output logic [dq_pkg::COUNT_W-1:0]      o_occupancy,
    output logic [dq_pkg::KEY_W-1:0]        o_front_key,
    output logic [dq_pkg::AGE_W-1:0]        o_front_age,
    output logic [dq_pkg::KEY_W-1:0]        o_removed_key,
    output logic [dq_pkg::AGE_W-1:0]        o_removed_age
);

    dq_pkg::t_rec                      r_cells [dq_pkg::DEPTH];
    dq_pkg::t_rec                      n_cells [dq_pkg::DEPTH];
    logic [dq_pkg::COUNT_W-1:0]        r_count;
    logic [dq_pkg::COUNT_W-1:0]        n_count;
    logic                              r_valid;
    dq_pkg::t_status                   r_status;
    dq_pkg::t_status                   n_status;
    dq_pkg::t_rec                      r_front;
    dq_pkg::t_rec                      n_front;
    dq_pkg::t_rec                      r_removed;
    dq_pkg::t_rec                      n_removed;
    dq_pkg::t_rec                      w_new;
    logic [dq_pkg::IDX_W-1:0]          w_last;
    logic                              w_full;
    logic                              w_empty;
    logic                              w_accept;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;
    assign w_new    = '{key: i_entry_key, age: i_entry_age};
    assign w_full   = (r_count == dq_pkg::COUNT_W'(dq_pkg::DEPTH));
    assign w_empty  = (r_count == '0);
    assign w_last   = r_count[dq_pkg::IDX_W-1:0] - 1'b1;

    always_comb begin
        n_cells   = r_cells;
        n_count   = r_count;
        n_status  = dq_pkg::ST_DONE;
        n_removed = '0;
        unique case (dq_pkg::t_cmd'(i_cmd))
            dq_pkg::CMD_PUSH_BACK: begin
                if (w_full) begin
                    n_status = dq_pkg::ST_FULL;
                end else begin
                    n_cells[r_count[dq_pkg::IDX_W-1:0]] = w_new;
                    n_count = r_count + 1'b1;
                end
            end
            dq_pkg::CMD_PUSH_FRONT: begin
                if (w_full) begin
                    n_status = dq_pkg::ST_FULL;
                end else begin
                    for (int i = 1; i < dq_pkg::DEPTH; i++) begin
                        n_cells[i] = r_cells[i-1];
                    end
                    n_cells[0] = w_new;
                    n_count = r_count + 1'b1;
                end
            end
            dq_pkg::CMD_POP_FRONT: begin
                if (w_empty) begin
                    n_status = dq_pkg::ST_EMPTY;
                end else begin
                    n_removed = r_cells[0];
                    for (int i = 0; i < dq_pkg::DEPTH - 1; i++) begin
                        n_cells[i] = r_cells[i+1];
                    end
                    n_count = r_count - 1'b1;
                end
            end
            dq_pkg::CMD_POP_BACK: begin
                if (w_empty) begin
                    n_status = dq_pkg::ST_EMPTY;
                end else begin
                    n_removed = r_cells[w_last];
                    n_count = r_count - 1'b1;
                end
            end
            dq_pkg::CMD_UPDATE_FRONT: begin
                if (w_empty) begin
                    n_status = dq_pkg::ST_EMPTY;
                end else begin
                    n_cells[0] = w_new;
                end
            end
            default: begin
            end
        endcase
        n_front = (n_count == '0) ? '0 : n_cells[0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_accept;
            if (w_accept) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cells   <= n_cells;
            r_status  <= n_status;
            r_front   <= n_front;
            r_removed <= n_removed;
        end
    end

    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_occupancy   = r_count;
    assign o_front_key   = r_front.key;
    assign o_front_age   = r_front.age;
    assign o_removed_key = r_removed.key;
    assign o_removed_age = r_removed.age;

endmodule

/* rtl/core/dq_checker.sv */
`timescale 1ns / 1ps

module dq_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    input  logic                            busy,
    input  logic [dq_pkg::CMD_W-1:0]        i_cmd,
    input  logic [dq_pkg::KEY_W-1:0]        i_entry_key,
    input  logic [dq_pkg::AGE_W-1:0]        i_entry_age,
    input  logic                            o_valid,
    input  logic [dq_pkg::STAT_W-1:0]       o_status,
    input  logic [dq_pkg::COUNT_W-1:0]      o_occupancy,
    input  logic [dq_pkg::KEY_W-1:0]        o_front_key,
    input  logic [dq_pkg::AGE_W-1:0]        o_front_age,
    input  logic [dq_pkg::KEY_W-1:0]        o_removed_key,
    input  logic [dq_pkg::AGE_W-1:0]        o_removed_age
);

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> o_valid)
        else $error("transfer without result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |=> !o_valid)
        else $error("result without transfer");

    a_empty_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_occupancy == '0) |-> (o_front_key == '0 && o_front_age == '0))
        else $error("front record shown on empty queue");

    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == dq_pkg::ST_EMPTY)
            |-> (o_occupancy == '0 && o_removed_key == '0 && o_removed_age == '0))
        else $error("empty status on occupied queue");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == dq_pkg::ST_FULL)
            |-> (o_occupancy == dq_pkg::COUNT_W'(dq_pkg::DEPTH)))
        else $error("full status below capacity");

endmodule

bind double_ended_queue_core dq_checker u_dq_checker (.*);

/* tb/sv/double_ended_queue_core_tb.sv */
`timescale 1ns / 1ps

module double_ended_queue_core_tb;

    localparam int                       CMD_LAST = (1 << dq_pkg::CMD_W) - 1;
    localparam logic [dq_pkg::KEY_W-1:0] KEY_MAX  = '1;
    localparam logic [dq_pkg::AGE_W-1:0] AGE_MAX  = '1;

    typedef struct {
        logic [dq_pkg::STAT_W-1:0]  status;
        logic [dq_pkg::COUNT_W-1:0] occupancy;
        logic [dq_pkg::KEY_W-1:0]   front_key;
        logic [dq_pkg::AGE_W-1:0]   front_age;
        logic [dq_pkg::KEY_W-1:0]   removed_key;
        logic [dq_pkg::AGE_W-1:0]   removed_age;
    } t_report;

    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       start       = 1'b0;
    logic                       busy;
    logic [dq_pkg::CMD_W-1:0]   i_cmd       = '0;
    logic [dq_pkg::KEY_W-1:0]   i_entry_key = '0;
    logic [dq_pkg::AGE_W-1:0]   i_entry_age = '0;
    logic                       o_valid;
    logic [dq_pkg::STAT_W-1:0]  o_status;
    logic [dq_pkg::COUNT_W-1:0] o_occupancy;
    logic [dq_pkg::KEY_W-1:0]   o_front_key;
    logic [dq_pkg::AGE_W-1:0]   o_front_age;
    logic [dq_pkg::KEY_W-1:0]   o_removed_key;
    logic [dq_pkg::AGE_W-1:0]   o_removed_age;

    dq_pkg::t_rec held_records[$];
    t_report      pending_reports[$];
    int           error_count     = 0;
    int           sent_count      = 0;
    int           checked_count   = 0;
    int           planned_fill    = 0;
    int           sender_idle_pct = 0;

    always #5 i_clk = ~i_clk;

    double_ended_queue_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_cmd         (i_cmd),
        .i_entry_key   (i_entry_key),
        .i_entry_age   (i_entry_age),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_occupancy   (o_occupancy),
        .o_front_key   (o_front_key),
        .o_front_age   (o_front_age),
        .o_removed_key (o_removed_key),
        .o_removed_age (o_removed_age)
    );

    function automatic t_report apply_command(logic [dq_pkg::CMD_W-1:0] cmd,
                                              logic [dq_pkg::KEY_W-1:0] key,
                                              logic [dq_pkg::AGE_W-1:0] age);
        t_report      rep;
        dq_pkg::t_rec rec;
        dq_pkg::t_rec gone;
        rec.key  = key;
        rec.age  = age;
        gone     = '0;
        rep.status = dq_pkg::ST_DONE;
        case (cmd)
            dq_pkg::CMD_PUSH_BACK, dq_pkg::CMD_PUSH_FRONT: begin
                if (held_records.size() >= dq_pkg::DEPTH) begin
                    rep.status = dq_pkg::ST_FULL;
                end else if (cmd == dq_pkg::CMD_PUSH_BACK) begin
                    held_records.push_back(rec);
                end else begin
                    held_records.push_front(rec);
                end
            end
            dq_pkg::CMD_POP_FRONT, dq_pkg::CMD_POP_BACK: begin
                if (held_records.size() == 0) begin
                    rep.status = dq_pkg::ST_EMPTY;
                end else if (cmd == dq_pkg::CMD_POP_FRONT) begin
                    gone = held_records.pop_front();
                end else begin
                    gone = held_records.pop_back();
                end
            end
            dq_pkg::CMD_UPDATE_FRONT: begin
                if (held_records.size() == 0) begin
                    rep.status = dq_pkg::ST_EMPTY;
                end else begin
                    held_records[0] = rec;
                end
            end
            default: begin
            end
        endcase
        rep.occupancy = dq_pkg::COUNT_W'(held_records.size());
        if (held_records.size() != 0) begin
            rep.front_key = held_records[0].key;
            rep.front_age = held_records[0].age;
        end else begin
            rep.front_key = '0;
            rep.front_age = '0;
        end
        rep.removed_key = gone.key;
        rep.removed_age = gone.age;
        return rep;
    endfunction

    function automatic void compare_field(string name, logic [dq_pkg::KEY_W-1:0] want,
                                          logic [dq_pkg::KEY_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge i_clk) begin : result_monitor
        t_report got;
        t_report want;
        if (i_rst_n) begin
            if (start && !busy) begin
                pending_reports.push_back(apply_command(i_cmd, i_entry_key, i_entry_age));
            end
            if (o_valid) begin
                checked_count++;
                if (pending_reports.size() == 0) begin
                    $error("result with no command outstanding");
                    error_count++;
                end else begin
                    want            = pending_reports.pop_front();
                    got.status      = o_status;
                    got.occupancy   = o_occupancy;
                    got.front_key   = o_front_key;
                    got.front_age   = o_front_age;
                    got.removed_key = o_removed_key;
                    got.removed_age = o_removed_age;
                    compare_field("status", dq_pkg::KEY_W'(want.status),
                                  dq_pkg::KEY_W'(got.status));
                    compare_field("occupancy", dq_pkg::KEY_W'(want.occupancy),
                                  dq_pkg::KEY_W'(got.occupancy));
                    compare_field("front_key", want.front_key, got.front_key);
                    compare_field("front_age", dq_pkg::KEY_W'(want.front_age),
                                  dq_pkg::KEY_W'(got.front_age));
                    compare_field("removed_key", want.removed_key, got.removed_key);
                    compare_field("removed_age", dq_pkg::KEY_W'(want.removed_age),
                                  dq_pkg::KEY_W'(got.removed_age));
                end
            end
        end
    end

    function automatic logic [dq_pkg::KEY_W-1:0] pick_key();
        case ($urandom_range(7, 0))
            0:       return '0;
            1:       return KEY_MAX;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_command(logic [dq_pkg::CMD_W-1:0] cmd,
                                logic [dq_pkg::KEY_W-1:0] key,
                                logic [dq_pkg::AGE_W-1:0] age);
        int gap;
        start       <= 1'b1;
        i_cmd       <= cmd;
        i_entry_key <= key;
        i_entry_age <= age;
        do @(posedge i_clk); while (busy);
        sent_count++;
        if ((cmd == dq_pkg::CMD_PUSH_BACK || cmd == dq_pkg::CMD_PUSH_FRONT)
                && planned_fill < dq_pkg::DEPTH) begin
            planned_fill++;
        end else if ((cmd == dq_pkg::CMD_POP_FRONT || cmd == dq_pkg::CMD_POP_BACK)
                && planned_fill > 0) begin
            planned_fill--;
        end
        gap = 0;
        while (gap < 40 && $urandom_range(99, 0) < sender_idle_pct) gap++;
        if (gap > 0) begin
            start       <= 1'b0;
            i_cmd       <= dq_pkg::CMD_W'($urandom_range(CMD_LAST, 0));
            i_entry_key <= $urandom;
            i_entry_age <= dq_pkg::AGE_W'($urandom_range(AGE_MAX, 0));
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (checked_count < sent_count) @(posedge i_clk);
    endtask

    task automatic test_empty_queue();
        send_command(dq_pkg::CMD_POP_FRONT, pick_key(),
                     dq_pkg::AGE_W'($urandom_range(AGE_MAX, 0)));
        send_command(dq_pkg::CMD_POP_BACK, pick_key(),
                     dq_pkg::AGE_W'($urandom_range(AGE_MAX, 0)));
        send_command(dq_pkg::CMD_UPDATE_FRONT, $urandom,
                     dq_pkg::AGE_W'($urandom_range(AGE_MAX, 0)));
        send_command(dq_pkg::CMD_W'(CMD_LAST), $urandom, AGE_MAX);
    endtask

    task automatic test_field_extremes();
        send_command(dq_pkg::CMD_PUSH_BACK, '0, '0);
        send_command(dq_pkg::CMD_PUSH_FRONT, KEY_MAX, AGE_MAX);
        send_command(dq_pkg::CMD_UPDATE_FRONT, $urandom,
                     dq_pkg::AGE_W'($urandom_range(AGE_MAX, 0)));
        send_command(dq_pkg::CMD_POP_BACK, $urandom,
                     dq_pkg::AGE_W'($urandom_range(AGE_MAX, 0)));
        send_command(dq_pkg::CMD_POP_FRONT, $urandom,
                     dq_pkg::AGE_W'($urandom_range(AGE_MAX, 0)));
    endtask

    task automatic test_full_queue();
        repeat (dq_pkg::DEPTH) begin
            send_command($urandom_range(1, 0) ? dq_pkg::CMD_PUSH_BACK : dq_pkg::CMD_PUSH_FRONT,
                         pick_key(), dq_pkg::AGE_W'($urandom_range(AGE_MAX, 0)));
        end
        send_command(dq_pkg::CMD_PUSH_BACK, $urandom,
                     dq_pkg::AGE_W'($urandom_range(AGE_MAX, 0)));
        send_command(dq_pkg::CMD_PUSH_FRONT, $urandom,
                     dq_pkg::AGE_W'($urandom_range(AGE_MAX, 0)));
        send_command(dq_pkg::CMD_W'(int'(dq_pkg::CMD_UPDATE_FRONT) + 1), $urandom, '0);
    endtask

    task automatic test_random_traffic(int items, int idle_pct);
        logic [dq_pkg::CMD_W-1:0] cmd;
        int                       pick;
        bit                       filling;
        sender_idle_pct = idle_pct;
        filling         = (planned_fill < dq_pkg::DEPTH);
        repeat (items) begin
            if (planned_fill == dq_pkg::DEPTH) begin
                filling = 1'b0;
            end else if (planned_fill == 0) begin
                filling = 1'b1;
            end else if ($urandom_range(31, 0) == 0) begin
                filling = !filling;
            end
            pick = $urandom_range(99, 0);
            if (pick < 4) begin
                cmd = dq_pkg::CMD_W'($urandom_range(CMD_LAST,
                                                    int'(dq_pkg::CMD_UPDATE_FRONT) + 1));
            end else if (pick < 14) begin
                cmd = dq_pkg::CMD_UPDATE_FRONT;
            end else if ((pick < 72) == filling) begin
                cmd = $urandom_range(1, 0) ? dq_pkg::CMD_PUSH_BACK : dq_pkg::CMD_PUSH_FRONT;
            end else begin
                cmd = $urandom_range(1, 0) ? dq_pkg::CMD_POP_BACK : dq_pkg::CMD_POP_FRONT;
            end
            send_command(cmd, pick_key(), dq_pkg::AGE_W'($urandom_range(AGE_MAX, 0)));
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_queue();
        test_field_extremes();
        test_full_queue();
        drain_results();
        test_random_traffic(260, 0);
        drain_results();
        test_random_traffic(200, 69);
        drain_results();
        test_random_traffic(200, 17);
        drain_results();
        test_random_traffic(190, 0);
        drain_results();
        repeat (4) @(posedge i_clk);
        if (error_count == 0 && pending_reports.size() == 0) begin
            $display("PASS");
        end else begin
            if (pending_reports.size() != 0) begin
                $error("%0d results never arrived", pending_reports.size());
            end
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #(5_000_000);
        $display("FAIL");
        $finish;
    end

endmodule
